### hw/rtl/lmm_pkg.sv
// Shared types and constants of the 3x3 local maximum marker.
// Holds the payload structs, register indexes and action codes.
// No dependencies.
package lmm_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int IDX_W     = 10;
  localparam int CFG_W     = 11;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = 3;
  localparam int OUT_PTR_W = 2;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_SIZE = 1'b1;

  localparam logic MODE_FOUR  = 1'b0;
  localparam logic MODE_EIGHT = 1'b1;

  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

  typedef struct packed {
    logic                action;
    logic [SAMPLE_W-1:0] sample;
  } lmm_in_t;

  typedef struct packed {
    logic             mark;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic             frame_end;
  } lmm_out_t;

endpackage

### hw/rtl/local_maximum_marker_3x3.sv
// A result passes the s1 and s2 stage registers before it enters the output queue.
// The mark of a pixel is caused by the pixel one row below and one column right.
// Throughput: one input transfer per cycle; the input stalls once four results are in flight.
// A four-entry result queue carries the output side through stalls of the consumer.
// Reset: synchronous, clears counters, window cells and queue; line store contents stay undefined.
// Mode resets to eight neighbors and image size to 1024, clamped to MAX_SIZE.
module local_maximum_marker_3x3 #(
  parameter int MAX_SIZE    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  lmm_pkg::lmm_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lmm_pkg::lmm_out_t          out_data,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [lmm_pkg::CFG_W-1:0]  cfg_data
);
  import lmm_pkg::*;

  localparam int CW       = $clog2(MAX_SIZE);
  localparam int SW       = $clog2(MAX_SIZE + 1);
  localparam int PW       = $clog2(MAX_SIZE + 3);
  localparam int W        = SAMPLE_BITS;
  localparam int SIDE_RST = (1024 > MAX_SIZE) ? MAX_SIZE : 1024;

  logic              mode_r;
  logic [SW-1:0]     side_r;
  logic [SW-1:0]     side_nxt;
  logic              size_wr;

  logic [CW-1:0]     in_col_r, in_col_nxt;
  logic [CW-1:0]     in_row_r, in_row_nxt;
  logic [PW-1:0]     pend_r, pend_nxt;
  logic [CW-1:0]     out_col_r, out_col_nxt;
  logic [CW-1:0]     out_row_r, out_row_nxt;

  logic              in_xfer, smp, flush;
  logic [SW-1:0]     col_inc, row_inc, ocol_inc, orow_inc;
  logic [PW-1:0]     pend_sat;
  logic              smp_emit, fl_emit;

  logic              s1_vld_r, s1_emit_r;
  logic [W-1:0]      s1_smp_r;
  logic [CW-1:0]     s1_col_r;
  logic              s2_emit_r, s2_win_r;

  logic [2*W-1:0]    lb_rd;
  logic [W-1:0]      up_rd, mid_rd;

  logic [W-1:0]      c0_t, c0_m, c0_b;
  logic [W-1:0]      c1_t, c1_m, c1_b;
  logic [W-1:0]      c2_t, c2_m, c2_b;

  logic              peak, interior, last_pix;
  lmm_out_t          res;
  logic [OUT_CNT_W-1:0] fifo_cnt;
  logic [3:0]        credit_used;

  // Configuration.
  assign size_wr = cfg_we && (cfg_index == REG_SIZE);

  always_comb begin
    if (cfg_data == '0) begin
      side_nxt = SW'(1);
    end else if (32'(cfg_data) > MAX_SIZE) begin
      side_nxt = SW'(MAX_SIZE);
    end else begin
      side_nxt = SW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_EIGHT;
      side_r <= SW'(SIDE_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE: mode_r <= cfg_data[0];
        REG_SIZE: side_r <= side_nxt;
        default: ;
      endcase
    end
  end

  // Input side control.
  assign credit_used = 4'(fifo_cnt) + 4'(s1_emit_r) + 4'(s2_emit_r);
  assign in_ready    = (credit_used < 4'(OUT_DEPTH));
  assign in_xfer     = in_valid && in_ready;
  assign smp         = in_xfer && (in_data.action == ACT_PUSH);
  assign flush       = in_xfer && (in_data.action == ACT_FLUSH);

  always_comb begin
    col_inc  = SW'(in_col_r) + SW'(1);
    row_inc  = SW'(in_row_r) + SW'(1);
    pend_sat = (pend_r < PW'(side_r) + PW'(2)) ? pend_r + PW'(1) : pend_r;
    smp_emit = (pend_sat > PW'(side_r) + PW'(1));
    fl_emit  = (in_row_r == '0) && (in_col_r == '0) && (pend_r != '0);
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    pend_nxt   = pend_r;
    if (size_wr) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
      pend_nxt   = '0;
    end else if (smp) begin
      pend_nxt = smp_emit ? pend_sat - PW'(1) : pend_sat;
      if (col_inc >= side_r) begin
        in_col_nxt = '0;
        in_row_nxt = (row_inc >= side_r) ? '0 : CW'(row_inc);
      end else begin
        in_col_nxt = CW'(col_inc);
      end
    end else if (flush && fl_emit) begin
      pend_nxt = pend_r - PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      pend_r    <= '0;
      s1_vld_r  <= 1'b0;
      s1_emit_r <= 1'b0;
      s2_emit_r <= 1'b0;
      s2_win_r  <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      pend_r    <= pend_nxt;
      s1_vld_r  <= smp;
      s1_emit_r <= (smp && smp_emit) || (flush && fl_emit);
      s2_emit_r <= s1_emit_r;
      s2_win_r  <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (smp) begin
      s1_smp_r <= W'(in_data.sample);
      s1_col_r <= in_col_r;
    end
  end

  // Line store: upper row in the high half, middle row in the low half.
  lmm_line_buf #(
    .W     (W),
    .DEPTH (MAX_SIZE),
    .AW    (CW)
  ) u_line_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (smp),
    .rd_addr (in_col_r),
    .rd_data (lb_rd),
    .wr_en   (s1_vld_r),
    .wr_addr (s1_col_r),
    .wr_data ({mid_rd, s1_smp_r})
  );

  assign up_rd  = lb_rd[2*W-1:W];
  assign mid_rd = lb_rd[W-1:0];

  // Window: three column cells, the newest column on the right.
  lmm_win_col #(.W(W)) u_col2 (
    .clk (clk), .rst_n (rst_n), .shift_en (s1_vld_r),
    .top_in (up_rd), .mid_in (mid_rd), .bot_in (s1_smp_r),
    .top_out (c2_t), .mid_out (c2_m), .bot_out (c2_b)
  );

  lmm_win_col #(.W(W)) u_col1 (
    .clk (clk), .rst_n (rst_n), .shift_en (s1_vld_r),
    .top_in (c2_t), .mid_in (c2_m), .bot_in (c2_b),
    .top_out (c1_t), .mid_out (c1_m), .bot_out (c1_b)
  );

  lmm_win_col #(.W(W)) u_col0 (
    .clk (clk), .rst_n (rst_n), .shift_en (s1_vld_r),
    .top_in (c1_t), .mid_in (c1_m), .bot_in (c1_b),
    .top_out (c0_t), .mid_out (c0_m), .bot_out (c0_b)
  );

  // Mark stage.
  always_comb begin
    peak = (c1_m > c0_m) && (c1_m > c2_m) && (c1_m > c1_t) && (c1_m > c1_b);
    if (mode_r == MODE_EIGHT) begin
      peak = peak && (c1_m > c0_t) && (c1_m > c2_t) && (c1_m > c0_b) && (c1_m > c2_b);
    end
    ocol_inc = SW'(out_col_r) + SW'(1);
    orow_inc = SW'(out_row_r) + SW'(1);
    interior = (out_row_r != '0) && (out_col_r != '0) &&
               (orow_inc < side_r) && (ocol_inc < side_r);
    last_pix = (orow_inc >= side_r) && (ocol_inc >= side_r);
    res.mark      = s2_win_r && interior && peak;
    res.row_index = IDX_W'(out_row_r);
    res.col_index = IDX_W'(out_col_r);
    res.frame_end = last_pix;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (size_wr) begin
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (s2_emit_r) begin
      if (ocol_inc >= side_r) begin
        out_col_nxt = '0;
        out_row_nxt = (orow_inc >= side_r) ? '0 : CW'(orow_inc);
      end else begin
        out_col_nxt = CW'(ocol_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  lmm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_emit_r),
    .push_data (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (fifo_cnt)
  );

  // The queue never takes more results than it has room for.
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    credit_used <= 4'(OUT_DEPTH))
    else $error("result queue credit exceeded");

  // The pending count stays within one row plus two pixels.
  a_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PW'(side_r) + PW'(2))
    else $error("pending count out of range");

  // Input and output positions stay inside the image.
  a_in_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (SW'(in_col_r) < side_r) && (SW'(in_row_r) < side_r))
    else $error("input position outside image");

  a_out_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (SW'(out_col_r) < side_r) && (SW'(out_row_r) < side_r))
    else $error("output position outside image");

  // A result caused by an input transfer moves from the first stage register to the second, which pushes it.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_emit_r |=> s2_emit_r)
    else $error("result lost between stages");

endmodule

### hw/rtl/lmm_win_col.sv
// One column cell of the 3x3 window: holds top, middle and bottom samples.
// Loads the column from its inputs, the right neighbor cell or the newest samples, on every shift.
// Depends on nothing but its width parameter.
module lmm_win_col #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         shift_en,
  input  logic [W-1:0] top_in,
  input  logic [W-1:0] mid_in,
  input  logic [W-1:0] bot_in,
  output logic [W-1:0] top_out,
  output logic [W-1:0] mid_out,
  output logic [W-1:0] bot_out
);

  logic [W-1:0] top_r;
  logic [W-1:0] mid_r;
  logic [W-1:0] bot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
      mid_r <= '0;
      bot_r <= '0;
    end else if (shift_en) begin
      top_r <= top_in;
      mid_r <= mid_in;
      bot_r <= bot_in;
    end
  end

  assign top_out = top_r;
  assign mid_out = mid_r;
  assign bot_out = bot_r;

endmodule

### hw/rtl/lmm_line_buf.sv
// Line store holding the upper and middle rows as one word per column.
// Registered read with forwarding of a write to the same column in that cycle.
// Depends on nothing but its parameters.
module lmm_line_buf #(
  parameter int W     = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output logic [2*W-1:0] rd_data,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  logic [2*W-1:0] wr_data
);

  logic [2*W-1:0] mem [DEPTH];
  logic [2*W-1:0] rd_q_r;
  logic [2*W-1:0] byp_data_r;
  logic           byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      byp_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule

### hw/rtl/lmm_out_fifo.sv
// Result queue between the mark stage and the output channel.
// Lets the input side keep going while a result waits for transfer.
// Depends on lmm_pkg.
module lmm_out_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  lmm_pkg::lmm_out_t         push_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lmm_pkg::lmm_out_t         out_data,
  output logic [lmm_pkg::OUT_CNT_W-1:0] count
);
  import lmm_pkg::*;

  lmm_out_t               mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_r;
  logic [OUT_PTR_W-1:0]   rd_ptr_r;
  logic [OUT_CNT_W-1:0]   cnt_r;
  logic                   pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr_r];
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OUT_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + OUT_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - OUT_CNT_W'(1);
      end
    end
  end

endmodule

### tb/sv/tb_local_maximum_marker_3x3.sv
`timescale 1ns / 1ps
// Self-checking testbench of the 3x3 local maximum marker: pixel and flush transfers are
// driven with random idling, every result is predicted or given by a directed table and compared on the output side.
// Depends on lmm_pkg and local_maximum_marker_3x3.
module tb_local_maximum_marker_3x3;
  import lmm_pkg::*;

  localparam int MAX_SIDE    = 1024;
  localparam int DRAIN_WAIT  = 16;
  localparam int RAND_PIXELS = 1150;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [1:0] {SRC_MODEL, SRC_NONE, SRC_GIVEN} mark_src_t;
  typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic             idx;
    logic [CFG_W-1:0] val;
    lmm_in_t          item;
    mark_src_t        src;
    lmm_out_t         given;
  } dir_row_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  lmm_in_t          in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  lmm_out_t         out_data;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data  = '0;

  mark_src_t in_src   = SRC_MODEL;
  lmm_out_t  in_given = '0;

  lmm_out_t expected_marks [$];
  dir_row_t dir_tab [$];

  int n_errors  = 0;
  int n_checked = 0;
  int n_peaks   = 0;
  int n_pixels  = 0;
  int n_writes  = 0;
  int sent_px   = 0;
  int tx_odds   = 0;
  int rx_odds   = 0;
  int rx_stall  = 0;
  bit rx_hold_req  = 1'b0;
  bit rx_hold_done = 1'b0;

  logic [SAMPLE_W-1:0] line_up  [MAX_SIDE];
  logic [SAMPLE_W-1:0] line_mid [MAX_SIDE];
  logic [SAMPLE_W-1:0] win [9];
  int unsigned         pos_row, pos_col, next_px, waiting;
  logic                cur_mode;
  logic [CFG_W-1:0]    cur_size;

  local_maximum_marker_3x3 u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned eff_side();
    if (cur_size == 0) return 1;
    if (cur_size > MAX_SIDE) return MAX_SIDE;
    return 32'(cur_size);
  endfunction

  function automatic bit center_is_peak();
    logic [SAMPLE_W-1:0] d;
    bit                  p;
    d = win[4];
    p = d > win[3] && d > win[5] && d > win[1] && d > win[7];
    if (cur_mode == MODE_EIGHT) begin
      p = p && d > win[0] && d > win[2] && d > win[6] && d > win[8];
    end
    return p;
  endfunction

  function automatic lmm_out_t next_mark(input bit use_win);
    int unsigned s, r, c;
    lmm_out_t    o;
    s = eff_side();
    r = next_px / s;
    c = next_px % s;
    o.mark      = use_win && r > 0 && c > 0 && r + 1 < s && c + 1 < s &&
                  center_is_peak();
    o.row_index = IDX_W'(r);
    o.col_index = IDX_W'(c);
    o.frame_end = (next_px + 1 >= s * s);
    next_px = o.frame_end ? 0 : next_px + 1;
    if (waiting > 0) waiting--;
    return o;
  endfunction

  task automatic predict_mark(input lmm_in_t it, output bit has, output lmm_out_t o);
    int unsigned s;
    s   = eff_side();
    has = 1'b0;
    o   = '0;
    if (it.action == ACT_FLUSH) begin
      if (pos_row == 0 && pos_col == 0 && waiting > 0) begin
        has = 1'b1;
        o   = next_mark(1'b0);
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        win[k * 3]     = win[k * 3 + 1];
        win[k * 3 + 1] = win[k * 3 + 2];
      end
      win[2] = line_up[pos_col];
      win[5] = line_mid[pos_col];
      win[8] = it.sample;
      line_up[pos_col]  = line_mid[pos_col];
      line_mid[pos_col] = it.sample;
      pos_col++;
      if (pos_col >= s) begin
        pos_col = 0;
        pos_row++;
        if (pos_row >= s) pos_row = 0;
      end
      if (waiting < s + 2) waiting++;
      if (waiting > s + 1) begin
        has = 1'b1;
        o   = next_mark(1'b1);
      end
    end
  endtask

  always @(posedge clk) begin : scoreboard
    bit       has_mark;
    lmm_out_t predicted;
    lmm_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_mark(in_data, has_mark, predicted);
        if (in_src == SRC_GIVEN) begin
          expected_marks.push_back(in_given);
        end else if (in_src == SRC_MODEL && has_mark) begin
          expected_marks.push_back(predicted);
        end
        if (in_data.action == ACT_PUSH) n_pixels++;
      end
      if (out_valid && out_ready) begin
        if (expected_marks.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected mark, expected none, got mark=%0d row=%0d col=%0d end=%0d",
                   $time, out_data.mark, out_data.row_index, out_data.col_index,
                   out_data.frame_end);
        end else begin
          want = expected_marks.pop_front();
          n_checked++;
          if (want.mark) n_peaks++;
          if (out_data.mark !== want.mark || out_data.row_index !== want.row_index ||
              out_data.col_index !== want.col_index ||
              out_data.frame_end !== want.frame_end) begin
            n_errors++;
            $display("%0t: expected m=%0d r=%0d c=%0d e=%0d, got m=%0d r=%0d c=%0d e=%0d",
                     $time, want.mark, want.row_index, want.col_index, want.frame_end,
                     out_data.mark, out_data.row_index, out_data.col_index,
                     out_data.frame_end);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall  <= 0;
    end else if (rx_hold_req && !rx_hold_done) begin
      rx_hold_done <= 1'b1;
      rx_stall     <= HOLD_CYCLES - 1;
      out_ready    <= 1'b0;
    end else if (rx_stall != 0) begin
      rx_stall  <= rx_stall - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_odds) begin
      rx_stall  <= $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input lmm_in_t it, input mark_src_t src, input lmm_out_t given);
    if (tx_odds != 0 && $urandom_range(0, 99) < tx_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    in_src   <= src;
    in_given <= given;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  task automatic send_flushes(input int count);
    lmm_in_t tick;
    tick.action = ACT_FLUSH;
    for (int i = 0; i < count; i++) begin
      tick.sample = SAMPLE_W'($urandom);
      send_item(tick, SRC_MODEL, '0);
    end
  endtask

  task automatic push_pixels(input int count, input int style);
    lmm_in_t px;
    px.action = ACT_PUSH;
    for (int i = 0; i < count; i++) begin
      if (sent_px > RAND_PIXELS - 250) begin
        tx_odds = 0;
        rx_odds = 0;
      end
      if ($urandom_range(0, 19) == 0) send_flushes(1);
      case (style)
        0: px.sample = SAMPLE_W'($urandom_range(0, 65535));
        1: px.sample = SAMPLE_W'($urandom_range(0, 3));
        default: begin
          px.sample = ($urandom_range(0, 7) == 0) ? SAMPLE_W'($urandom_range(1000, 65535)) :
                                                    SAMPLE_W'($urandom_range(0, 999));
        end
      endcase
      send_item(px, SRC_MODEL, '0);
      sent_px++;
    end
  endtask

  task automatic drain_marks();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_marks.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_MODE) begin
      cur_mode = val[0];
    end else begin
      cur_size = val;
      pos_row  = 0;
      pos_col  = 0;
      next_px  = 0;
      waiting  = 0;
    end
    n_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic lmm_out_t mark_of(input bit m, input int r, input int c, input bit fe);
    lmm_out_t o;
    o.mark      = m;
    o.row_index = IDX_W'(r);
    o.col_index = IDX_W'(c);
    o.frame_end = fe;
    return o;
  endfunction

  function automatic dir_row_t reg_row(input logic idx, input logic [CFG_W-1:0] val);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_REG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  function automatic dir_row_t item_row(input logic act, input logic [SAMPLE_W-1:0] smp,
                                        input mark_src_t src, input lmm_out_t given);
    dir_row_t r;
    r             = '0;
    r.kind        = ROW_ITEM;
    r.item.action = act;
    r.item.sample = smp;
    r.src         = src;
    r.given       = given;
    return r;
  endfunction

  initial begin
    logic [CFG_W-1:0] size_val;
    int unsigned      side_px;
    int               frames;
    int               phase;

    foreach (line_up[i]) begin
      line_up[i]  = '0;
      line_mid[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    pos_row  = 0;
    pos_col  = 0;
    next_px  = 0;
    waiting  = 0;
    cur_mode = MODE_EIGHT;
    cur_size = SIZE_RESET;

    // Smallest frame with an interior pixel, then the side-one frame where every pixel is the last.
    dir_tab.push_back(reg_row(REG_SIZE, 11'd3));
    dir_tab.push_back(item_row(ACT_PUSH, 16'd0, SRC_NONE, '0));
    dir_tab.push_back(item_row(ACT_PUSH, 16'd1, SRC_NONE, '0));
    dir_tab.push_back(item_row(ACT_PUSH, 16'd2, SRC_NONE, '0));
    dir_tab.push_back(item_row(ACT_FLUSH, 16'hFFFF, SRC_NONE, '0));
    dir_tab.push_back(item_row(ACT_PUSH, 16'd3, SRC_NONE, '0));
    dir_tab.push_back(item_row(ACT_PUSH, 16'hFFFF, SRC_GIVEN, mark_of(0, 0, 0, 0)));
    dir_tab.push_back(item_row(ACT_PUSH, 16'd5, SRC_GIVEN, mark_of(0, 0, 1, 0)));
    dir_tab.push_back(item_row(ACT_PUSH, 16'd6, SRC_GIVEN, mark_of(0, 0, 2, 0)));
    dir_tab.push_back(item_row(ACT_PUSH, 16'd7, SRC_GIVEN, mark_of(0, 1, 0, 0)));
    dir_tab.push_back(item_row(ACT_PUSH, 16'd8, SRC_GIVEN, mark_of(1, 1, 1, 0)));
    dir_tab.push_back(item_row(ACT_FLUSH, 16'd0, SRC_GIVEN, mark_of(0, 1, 2, 0)));
    dir_tab.push_back(item_row(ACT_FLUSH, 16'd0, SRC_GIVEN, mark_of(0, 2, 0, 0)));
    dir_tab.push_back(item_row(ACT_FLUSH, 16'd0, SRC_GIVEN, mark_of(0, 2, 1, 0)));
    dir_tab.push_back(item_row(ACT_FLUSH, 16'd0, SRC_GIVEN, mark_of(0, 2, 2, 1)));
    dir_tab.push_back(item_row(ACT_FLUSH, 16'd0, SRC_NONE, '0));
    dir_tab.push_back(reg_row(REG_MODE, CFG_W'(MODE_FOUR)));
    dir_tab.push_back(reg_row(REG_SIZE, 11'd0));
    dir_tab.push_back(item_row(ACT_PUSH, 16'hFFFF, SRC_NONE, '0));
    dir_tab.push_back(item_row(ACT_PUSH, 16'd0, SRC_NONE, '0));
    dir_tab.push_back(item_row(ACT_PUSH, 16'd7, SRC_GIVEN, mark_of(0, 0, 0, 1)));
    dir_tab.push_back(item_row(ACT_FLUSH, 16'd0, SRC_GIVEN, mark_of(0, 0, 0, 1)));
    dir_tab.push_back(item_row(ACT_FLUSH, 16'd0, SRC_GIVEN, mark_of(0, 0, 0, 1)));
    dir_tab.push_back(item_row(ACT_FLUSH, 16'd0, SRC_NONE, '0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_odds = 20;
    rx_odds = 20;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        drain_marks();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_item(dir_tab[i].item, dir_tab[i].src, dir_tab[i].given);
      end
    end

    sent_px = 0;
    phase   = 0;
    while (sent_px < RAND_PIXELS || phase < 3) begin
      if (sent_px > RAND_PIXELS - 250) begin
        tx_odds = 0;
        rx_odds = 0;
      end else begin
        tx_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        rx_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      case ($urandom_range(0, 9))
        0: size_val = 11'd0;
        1: size_val = 11'd1;
        2: size_val = 11'd2;
        3: size_val = 11'd3;
        4, 5, 6, 7: size_val = CFG_W'($urandom_range(4, 8));
        default: size_val = CFG_W'($urandom_range(9, 20));
      endcase
      drain_marks();
      if (phase == 2) begin
        size_val    = 11'd16;
        tx_odds     = 0;
        rx_hold_req = 1'b1;
      end
      write_reg(REG_MODE, CFG_W'($urandom_range(0, 1)));
      write_reg(REG_SIZE, size_val);
      side_px = (size_val == 0) ? 1 : 32'(size_val);
      frames  = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        push_pixels(side_px * side_px, $urandom_range(0, 2));
        if (f + 1 < frames && $urandom_range(0, 3) == 0) drain_marks();
      end
      send_flushes(side_px + 1 + $urandom_range(0, 2));
      phase++;
    end
    drain_marks();

    $display("Checked %0d marks (%0d peaks) from %0d pixel transfers across %0d register writes.",
             n_checked, n_peaks, n_pixels, n_writes);
    $display("Both neighborhood modes, sides 1 to 20 with the zero size, flush ticks and stalls.");
    if (n_errors == 0) begin
      $display("PASS local_maximum_marker_3x3");
    end else begin
      $display("FAIL local_maximum_marker_3x3");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAIL local_maximum_marker_3x3");
    $finish;
  end

endmodule
